@@ hdl/swsr_pkg.sv @@
// ----------------------------------------------------------------------------
// swsr_pkg: shared types and constants of the single-wire sensor reader
// Phase codes, register indexes, result record and stream widths.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package swsr_pkg;

  // Bits shifted into one received byte
  localparam int unsigned BitsPerByte = 8;
  localparam int unsigned BitIdxW     = $clog2(BitsPerByte);

  // Default tick counter width
  localparam int unsigned TickCounterBitsDef = 16;

  // Configuration port
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned ReqLowW  = 16;
  localparam int unsigned DelayW   = 8;
  localparam int unsigned FrameW   = 4;
  localparam int unsigned ByteIdxW = 3;
  localparam int unsigned MaxFrameBytes = 8;

  localparam logic [ReqLowW-1:0] ReqLowRst = ReqLowW'(20000);
  localparam logic [DelayW-1:0]  DelayRst  = DelayW'(30);
  localparam logic [FrameW-1:0]  FrameRst  = FrameW'(5);

  // Stream widths (fields packed from bit 0, padded to whole bytes)
  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    REG_REQUEST_LOW  = 2'd0,
    REG_SAMPLE_DELAY = 2'd1,
    REG_FRAME_BYTES  = 2'd2
  } cfg_reg_e;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_REQUEST   = 3'd1,
    PH_ACK_LOW   = 3'd2,
    PH_ACK_HIGH  = 3'd3,
    PH_ACK_FALL  = 3'd4,
    PH_BIT_HIGH  = 3'd5,
    PH_BIT_DELAY = 3'd6,
    PH_BIT_FALL  = 3'd7
  } phase_e;

  // One result item
  typedef struct packed {
    logic                   busy_res;
    logic                   last_byte;
    logic [BitsPerByte-1:0] data_byte;
    logic                   byte_valid;
    logic                   drive_low;
  } result_t;

endpackage

`default_nettype wire

@@ hdl/single_wire_sensor_reader.sv @@
// ----------------------------------------------------------------------------
// single_wire_sensor_reader: pulse-width bit receiver for a single-wire bus
// Each item is one microsecond tick; every tick gives one result item.
// ----------------------------------------------------------------------------
//  channel   dir  handshake                  payload
//  s_axis    in   s_axis_tvalid/tready       tdata: start_req, line_level
//  m_axis    out  m_axis_tvalid/tready       tdata: drive_low, byte_valid,
//                                            data_byte, busy_res; tlast
//  cfg       in   cfg_we_i (no wait)         cfg_index_i, cfg_data_i
//
//  One tick item per clock while s_axis_tready is high; its result is
//  registered before it shows on m_axis. The rate is set by the sequencer step in
//  swsr_core, which is a single level of compare and increment logic.
//  A skid register holds one result while m_axis stalls; s_axis_tready
//  drops only while that skid register is full.
//  Reset clears the sequence to idle and loads the register defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module single_wire_sensor_reader #(
  parameter int unsigned TICK_COUNTER_BITS = swsr_pkg::TickCounterBitsDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // configuration writes
  input  wire logic                          cfg_we_i,
  input  wire logic [swsr_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [swsr_pkg::CfgDataW-1:0] cfg_data_i,
  // tick items
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [swsr_pkg::InDataW-1:0]  s_axis_tdata,  // [0] start_req, [1] line_level
  // result items
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [swsr_pkg::OutDataW-1:0]      m_axis_tdata,  // [0] drive_low, [1] byte_valid,
                                                            // [9:2] data_byte, [10] busy_res
  output logic                               m_axis_tlast   // last_byte
);
  import swsr_pkg::*;

  logic    accept;
  result_t res;

  assign accept = s_axis_tvalid && s_axis_tready;

  swsr_core #(
    .TICK_COUNTER_BITS(TICK_COUNTER_BITS)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .step_i       (accept),
    .start_req_i  (s_axis_tdata[0]),
    .line_level_i (s_axis_tdata[1]),
    .result_o     (res)
  );

  // Output register with a skid stage behind it
  logic    out_vld_q, skid_vld_q;
  result_t out_q, skid_q;
  logic    out_free;

  assign out_free      = !out_vld_q || m_axis_tready;
  assign s_axis_tready = !skid_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q  <= skid_vld_q || accept;
      skid_vld_q <= 1'b0;
    end else if (accept) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= skid_vld_q ? skid_q : res;
    end else if (accept) begin
      skid_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tlast  = out_q.last_byte;
  assign m_axis_tdata  = OutDataW'({out_q.busy_res, out_q.data_byte,
                                    out_q.byte_valid, out_q.drive_low});

endmodule

`default_nettype wire

@@ hdl/swsr_core.sv @@
// ----------------------------------------------------------------------------
// swsr_core: bus sequencer and bit receiver
// Holds the configuration and sequence state; one tick is processed per
// step, and the result of that tick is computed in the same cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module swsr_core #(
  parameter int unsigned TICK_COUNTER_BITS = swsr_pkg::TickCounterBitsDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [swsr_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [swsr_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire logic                          step_i,
  input  wire logic                          start_req_i,
  input  wire logic                          line_level_i,
  output swsr_pkg::result_t                  result_o
);
  import swsr_pkg::*;

  localparam int unsigned TickW = TICK_COUNTER_BITS;
  localparam int unsigned CmpW  = (TickW > ReqLowW) ? TickW : ReqLowW;
  localparam logic [TickW-1:0] TickSat = {TickW{1'b1}};
  localparam logic [CmpW-1:0]  TickMax = CmpW'(TickSat);
  localparam logic [CmpW-1:0]  CmpOne  = CmpW'(1);

  // Configuration registers
  logic [ReqLowW-1:0] req_low_q;
  logic [DelayW-1:0]  delay_q;
  logic [FrameW-1:0]  frame_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_low_q <= ReqLowRst;
      delay_q   <= DelayRst;
      frame_q   <= FrameRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_REQUEST_LOW:  req_low_q <= cfg_data_i[ReqLowW-1:0];
        REG_SAMPLE_DELAY: delay_q   <= cfg_data_i[DelayW-1:0];
        REG_FRAME_BYTES:  frame_q   <= cfg_data_i[FrameW-1:0];
        default: ;
      endcase
    end
  end

  // Clipped targets: zero acts as one, anything past the counter saturates
  logic [CmpW-1:0]   req_ext, dly_ext, req_tgt, dly_tgt;
  logic [FrameW-1:0] nbytes;

  always_comb begin
    req_ext = CmpW'(req_low_q);
    dly_ext = CmpW'(delay_q);
    req_tgt = (req_ext == '0) ? CmpOne : req_ext;
    dly_tgt = (dly_ext == '0) ? CmpOne : dly_ext;
    if (req_tgt > TickMax) req_tgt = TickMax;
    if (dly_tgt > TickMax) dly_tgt = TickMax;
    nbytes = frame_q;
    if (nbytes == '0) nbytes = FrameW'(1);
    if (nbytes > FrameW'(MaxFrameBytes)) nbytes = FrameW'(MaxFrameBytes);
  end

  // Sequence state
  phase_e                 phase_q, phase_d;
  logic [TickW-1:0]       tick_q, tick_d;
  logic [BitIdxW-1:0]     bit_q, bit_d;
  logic [ByteIdxW-1:0]    byte_q, byte_d;
  logic [BitsPerByte-1:0] shift_q, shift_d;

  // A start overrides whatever sequence was running
  phase_e                 cur_phase;
  logic [TickW-1:0]       cur_tick, tick_inc;
  logic [BitIdxW-1:0]     cur_bit;
  logic [ByteIdxW-1:0]    cur_byte;
  logic [BitsPerByte-1:0] cur_shift;
  logic                   byte_done, frame_end;

  always_comb begin
    cur_phase = start_req_i ? PH_REQUEST : phase_q;
    cur_tick  = start_req_i ? '0 : tick_q;
    cur_bit   = start_req_i ? '0 : bit_q;
    cur_byte  = start_req_i ? '0 : byte_q;
    cur_shift = start_req_i ? '0 : shift_q;
    tick_inc  = (cur_tick == TickSat) ? cur_tick : cur_tick + TickW'(1);
    byte_done = (cur_phase == PH_BIT_FALL) && !line_level_i && (cur_bit == '0);
    frame_end = ({1'b0, cur_byte} + FrameW'(1)) >= nbytes;
  end

  // Next state
  always_comb begin
    phase_d = cur_phase;
    tick_d  = cur_tick;
    bit_d   = cur_bit;
    byte_d  = cur_byte;
    shift_d = cur_shift;
    unique case (cur_phase)
      PH_IDLE: ;
      PH_REQUEST: begin
        if (CmpW'(tick_inc) >= req_tgt) begin
          phase_d = PH_ACK_LOW;
          tick_d  = '0;
        end else begin
          tick_d = tick_inc;
        end
      end
      PH_ACK_LOW:  if (!line_level_i) phase_d = PH_ACK_HIGH;
      PH_ACK_HIGH: if (line_level_i)  phase_d = PH_ACK_FALL;
      PH_ACK_FALL: if (!line_level_i) phase_d = PH_BIT_HIGH;
      PH_BIT_HIGH: begin
        if (line_level_i) begin
          phase_d = PH_BIT_DELAY;
          tick_d  = '0;
        end
      end
      PH_BIT_DELAY: begin
        if (CmpW'(tick_inc) >= dly_tgt) begin
          shift_d = {cur_shift[BitsPerByte-2:0], line_level_i};
          bit_d   = cur_bit + BitIdxW'(1);
          tick_d  = '0;
          phase_d = PH_BIT_FALL;
        end else begin
          tick_d = tick_inc;
        end
      end
      PH_BIT_FALL: begin
        if (!line_level_i) begin
          phase_d = PH_BIT_HIGH;
          if (byte_done) begin
            shift_d = '0;
            if (frame_end) begin
              byte_d  = '0;
              phase_d = PH_IDLE;
            end else begin
              byte_d = cur_byte + ByteIdxW'(1);
            end
          end
        end
      end
    endcase
  end

  // Result of this tick
  always_comb begin
    result_o.drive_low  = (cur_phase == PH_REQUEST);
    result_o.byte_valid = byte_done;
    result_o.data_byte  = byte_done ? cur_shift : '0;
    result_o.last_byte  = byte_done && frame_end;
    result_o.busy_res   = (phase_d != PH_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      tick_q  <= '0;
      bit_q   <= '0;
      byte_q  <= '0;
      shift_q <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      tick_q  <= tick_d;
      bit_q   <= bit_d;
      byte_q  <= byte_d;
      shift_q <= shift_d;
    end
  end

endmodule

`default_nettype wire

@@ hdl/swsr_checker.sv @@
// ----------------------------------------------------------------------------
// swsr_checker: port-level checks of the single-wire sensor reader
// Watches the result stream for field combinations the receiver never makes,
// and checks the skid limit and that a stalled result holds.
`timescale 1ns / 1ps
`default_nettype none

module swsr_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          cfg_we_i,
  input wire logic [swsr_pkg::CfgIdxW-1:0]  cfg_index_i,
  input wire logic [swsr_pkg::CfgDataW-1:0] cfg_data_i,
  input wire logic                          s_axis_tvalid,
  input wire logic                          s_axis_tready,
  input wire logic [swsr_pkg::InDataW-1:0]  s_axis_tdata,
  input wire logic                          m_axis_tvalid,
  input wire logic                          m_axis_tready,
  input wire logic [swsr_pkg::OutDataW-1:0] m_axis_tdata,
  input wire logic                          m_axis_tlast
);
  import swsr_pkg::*;

  // The frame's final byte ends the sequence
  a_last_ends_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[1] && !m_axis_tdata[10])
    else $error("last byte without byte_valid or with busy set");

  // Driving the request pulse means a sequence is running, with no byte
  a_drive_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[10] && !m_axis_tdata[1])
    else $error("drive_low outside a running sequence or with a byte");

  // No byte means a zero data field
  a_data_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[1] |-> m_axis_tdata[9:2] == '0)
    else $error("data_byte nonzero without byte_valid");

  // Only one result can be buffered, so input taken during a stall blocks input
  a_skid_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready && s_axis_tvalid && s_axis_tready
    |=> !s_axis_tready || m_axis_tready)
    else $error("input accepted while both result registers are full");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
    && $stable(m_axis_tlast))
    else $error("result changed while stalled");

endmodule

bind single_wire_sensor_reader swsr_checker u_swsr_checker (.*);

`default_nettype wire

@@ bench/single_wire_sensor_reader_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// single_wire_sensor_reader_tb: self-checking bench for the sensor reader
// Drives tick items (start request, line level) that mimic a sensor's
// acknowledge and pulse-width bits, together with noise and aborted frames.
// A cycle-free model of the sequencer predicts each result item that has no
// hand-written expectation, and a queue compares them in order, field by
// field. Register settings cover the reset values, zero values, frame lengths
// above eight and the maxima, with random idling on the tick stream and random
// stalls on the result stream.

module single_wire_sensor_reader_tb;
  import swsr_pkg::*;

  localparam int WatchdogLimit = 4000;
  localparam int TailCycles    = 8;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  // Directed tick with an optional hand-written expected result
  typedef struct packed {
    logic    start_req;
    logic    line_level;
    logic    typed;
    result_t res;
  } tick_row_t;

  localparam result_t IdleRes = '0;
  localparam result_t ReqRes  = '{busy_res: 1'b1, last_byte: 1'b0, data_byte: 8'h00,
                                  byte_valid: 1'b0, drive_low: 1'b1};

  localparam int DirCount = 8;
  localparam tick_row_t DirRows [DirCount] = '{
    '{1'b0, 1'b0, 1'b1, IdleRes},   // idle, line low
    '{1'b0, 1'b1, 1'b1, IdleRes},   // idle, line high
    '{1'b1, 1'b1, 1'b1, ReqRes},    // start, line ignored
    '{1'b1, 1'b0, 1'b1, ReqRes},    // start while requesting
    '{1'b0, 1'b1, 1'b0, IdleRes},
    '{1'b0, 1'b0, 1'b0, IdleRes},
    '{1'b1, 1'b0, 1'b1, ReqRes},
    '{1'b0, 1'b1, 1'b0, IdleRes}
  };

  logic clk_i;
  logic rst_ni = 1'b0;

  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i = REG_REQUEST_LOW;
  logic [CfgDataW-1:0] cfg_data_i  = '0;

  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tlast;

  // Hand-written expectation travels with the item it belongs to
  logic    row_typed = 1'b0;
  result_t row_res   = '0;

  int unsigned tx_pct = 0;
  int unsigned rx_pct = 0;

  // Sequencer shadow: registers and state
  logic [ReqLowW-1:0]            req_q   = ReqLowRst;
  logic [DelayW-1:0]             dly_q   = DelayRst;
  logic [FrameW-1:0]             frm_q   = FrameRst;
  phase_e                        phase_q = PH_IDLE;
  logic [TickCounterBitsDef-1:0] ticks_q = '0;
  logic [BitIdxW-1:0]            bit_q   = '0;
  logic [ByteIdxW-1:0]           byte_q  = '0;
  logic [BitsPerByte-1:0]        shreg_q = '0;

  result_t pending_results [$];
  int      mismatches   = 0;
  int      stall_cycles = 0;
  int      items_sent   = 0;
  int      cut_at       = 0;
  int      frame_sent   = 0;

  single_wire_sensor_reader u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),   // [0] start_req, [1] line_level
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),   // [0] drive_low, [1] byte_valid, [9:2] data_byte,
                                    // [10] busy_res
    .m_axis_tlast (m_axis_tlast)    // last_byte
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // One tick of the sequencer; returns the result item it produces
  function automatic result_t step_sequence(input logic st, input logic ln);
    result_t     r;
    int unsigned nb;
    r = '0;
    if (st) begin
      phase_q = PH_REQUEST;
      ticks_q = '0;
      bit_q   = '0;
      byte_q  = '0;
      shreg_q = '0;
    end
    case (phase_q)
      PH_REQUEST: begin
        r.drive_low = 1'b1;
        if (ticks_q != '1) ticks_q++;
        if (ticks_q >= ((req_q == '0) ? 16'd1 : req_q)) begin
          phase_q = PH_ACK_LOW;
          ticks_q = '0;
        end
      end
      PH_ACK_LOW:  if (!ln) phase_q = PH_ACK_HIGH;
      PH_ACK_HIGH: if (ln) phase_q = PH_ACK_FALL;
      PH_ACK_FALL: if (!ln) phase_q = PH_BIT_HIGH;
      PH_BIT_HIGH: if (ln) begin
        phase_q = PH_BIT_DELAY;
        ticks_q = '0;
      end
      PH_BIT_DELAY: begin
        if (ticks_q != '1) ticks_q++;
        if (ticks_q >= ((dly_q == '0) ? 16'd1 : {8'd0, dly_q})) begin
          shreg_q = {shreg_q[BitsPerByte-2:0], ln};
          bit_q++;
          ticks_q = '0;
          phase_q = PH_BIT_FALL;
        end
      end
      PH_BIT_FALL: if (!ln) begin
        if (bit_q == '0) begin
          // frame length clipped to 1..8
          nb = (frm_q == '0) ? 1 : ((frm_q > MaxFrameBytes) ? MaxFrameBytes : frm_q);
          r.byte_valid = 1'b1;
          r.data_byte  = shreg_q;
          shreg_q      = '0;
          if (byte_q + 1 >= nb) begin
            r.last_byte = 1'b1;
            byte_q      = '0;
            phase_q     = PH_IDLE;
          end else begin
            byte_q++;
            phase_q = PH_BIT_HIGH;
          end
        end else begin
          phase_q = PH_BIT_HIGH;
        end
      end
      default: ;
    endcase
    r.busy_res = (phase_q != PH_IDLE);
    return r;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Result checking, expectation capture and watchdog
  always @(posedge clk_i) begin : result_check
    result_t got;
    result_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.drive_low  = m_axis_tdata[0];
        got.byte_valid = m_axis_tdata[1];
        got.data_byte  = m_axis_tdata[9:2];
        got.busy_res   = m_axis_tdata[10];
        got.last_byte  = m_axis_tlast;
        if (pending_results.size() == 0) begin
          $display("%0t ns: result item with none expected, expected none, actual %h",
                   $time, got);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          check_field("drive_low", 8'(want.drive_low), 8'(got.drive_low));
          check_field("byte_valid", 8'(want.byte_valid), 8'(got.byte_valid));
          check_field("data_byte", want.data_byte, got.data_byte);
          check_field("last_byte", 8'(want.last_byte), 8'(got.last_byte));
          check_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        want = step_sequence(s_axis_tdata[0], s_axis_tdata[1]);
        if (row_typed) want = row_res;
        pending_results.push_back(want);
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= WatchdogLimit) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Result side stalls
  always @(posedge clk_i) begin
    m_axis_tready <= !($urandom_range(99) < rx_pct);
  end

  task automatic drive_tick(input logic st, input logic ln, input logic typed,
                            input result_t res);
    while ($urandom_range(99) < tx_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(InDataW-2){1'b0}}, ln, st};
    row_typed     <= typed;
    row_res       <= res;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
  endtask

  // Tick of a sensor frame; dropped once an aborted frame reaches its cut
  task automatic frame_tick(input logic st, input logic ln);
    if (cut_at != 0 && frame_sent >= cut_at) return;
    frame_sent++;
    drive_tick(st, ln, 1'b0, IdleRes);
  endtask

  // Request, acknowledge and frame_bytes bytes of pulse-width bits;
  // a nonzero cap ends the frame after that many ticks at the latest
  task automatic send_frame(input bit aborted, input int unsigned cap);
    int unsigned r_eff;
    int unsigned d_eff;
    int unsigned nb;
    int unsigned h;
    logic [7:0]  val;
    r_eff = (req_q == '0) ? 1 : req_q;
    d_eff = (dly_q == '0) ? 1 : dly_q;
    nb    = (frm_q == '0) ? 1 : ((frm_q > MaxFrameBytes) ? MaxFrameBytes : frm_q);
    frame_sent = 0;
    cut_at = aborted ? $urandom_range(r_eff + nb * 8 * (d_eff + 3), 1) : 0;
    if (cap != 0 && (cut_at == 0 || cut_at > cap)) cut_at = cap;
    frame_tick(1'b1, 1'($urandom_range(1)));
    for (int i = 1; i < r_eff; i++) frame_tick(1'b0, 1'($urandom_range(1)));
    repeat ($urandom_range(3, 1)) frame_tick(1'b0, 1'b0);
    repeat ($urandom_range(3, 1)) frame_tick(1'b0, 1'b1);
    for (int k = 0; k < nb; k++) begin
      case ($urandom_range(7))
        0:       val = 8'h00;
        1:       val = 8'hFF;
        default: val = 8'($urandom_range(255));
      endcase
      for (int b = 7; b >= 0; b--) begin
        repeat ($urandom_range(3, 1)) frame_tick(1'b0, 1'b0);
        frame_tick(1'b0, 1'b1);
        // a zero bit falls before the sample point, a one bit holds past it
        h = $urandom_range(d_eff, 1);
        for (int j = 1; j <= d_eff; j++) frame_tick(1'b0, val[b] ? 1'b1 : (j < h));
        if (val[b]) repeat ($urandom_range(2)) frame_tick(1'b0, 1'b1);
      end
    end
    repeat ($urandom_range(4, 1)) frame_tick(1'b0, 1'b0);
    cut_at = 0;
  endtask

  task automatic send_noise(input int n);
    repeat (n) drive_tick(($urandom_range(15) == 0), 1'($urandom_range(1)), 1'b0, IdleRes);
  endtask

  // Stop the tick stream and wait for every pending result
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CfgDataW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    case (idx)
      REG_REQUEST_LOW:  req_q = val[ReqLowW-1:0];
      REG_SAMPLE_DELAY: dly_q = val[DelayW-1:0];
      REG_FRAME_BYTES:  frm_q = val[FrameW-1:0];
      default: ;
    endcase
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_idling(input idle_mode_e mode);
    case (mode)
      IDLE_SENDER:   begin tx_pct <= 69; rx_pct <= 0;  end
      IDLE_RECEIVER: begin tx_pct <= 0;  rx_pct <= 69; end
      IDLE_BOTH:     begin tx_pct <= 6;  rx_pct <= 6;  end
      default:       begin tx_pct <= 0;  rx_pct <= 0;  end
    endcase
  endtask

  // One register setting: a clean frame first (capped when cap is nonzero),
  // then a mix of frames, aborted frames and noise until the item budget is spent
  task automatic run_phase(input logic [15:0] req, input logic [7:0] dly, input logic [3:0] frm,
                           input idle_mode_e mode, input int budget, input int unsigned cap);
    int first;
    int pick;
    drain();
    write_reg(REG_REQUEST_LOW, req);
    write_reg(REG_SAMPLE_DELAY, {8'd0, dly});
    write_reg(REG_FRAME_BYTES, {12'd0, frm});
    set_idling(mode);
    first = items_sent;
    send_frame(1'b0, cap);
    while (items_sent - first < budget) begin
      pick = $urandom_range(9);
      if (pick == 0) send_noise($urandom_range(20, 1));
      else send_frame(pick == 1, 0);
    end
  endtask

  initial begin : main_seq
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed ticks at the reset settings
    for (int i = 0; i < DirCount; i++)
      drive_tick(DirRows[i].start_req, DirRows[i].line_level, DirRows[i].typed,
                 DirRows[i].res);

    // Opening ticks of a frame at the reset settings, restarting the request above
    send_frame(1'b0, 50);

    run_phase(16'd1, 8'd1, 4'd1, IDLE_NONE, 100, 0);
    run_phase(16'd0, 8'd0, 4'd0, IDLE_SENDER, 100, 0);
    run_phase(16'd3, 8'd1, 4'd15, IDLE_RECEIVER, 1, 0);
    run_phase(16'd6, 8'd2, 4'd2, IDLE_BOTH, 60, 0);
    // Register maxima: the long request, then one sample at the longest delay
    run_phase(16'hFFFF, 8'hFF, 4'd8, IDLE_NONE, 1, 50);
    run_phase(16'd2, 8'hFF, 4'd1, IDLE_NONE, 1, 270);
    for (int k = 0; k < 4; k++)
      run_phase(16'($urandom_range(10, 1)), 8'($urandom_range(4, 1)),
                4'($urandom_range(2, 1)), idle_mode_e'(k), 40, 0);

    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (mismatches == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

@@ single_wire_sensor_reader.f @@
hdl/swsr_pkg.sv
hdl/swsr_core.sv
hdl/single_wire_sensor_reader.sv
hdl/swsr_checker.sv
bench/single_wire_sensor_reader_tb.sv
